// ===== rtl/crg_pkg.sv =====
// ----------------------------------------------------------------------------
// crg_pkg - shared types and constants of the column rain character generator
// Seed arithmetic constants, symbol table lookup, digit-serial residue step,
// per-column entry layout and the state machine encodings.
// ----------------------------------------------------------------------------
package crg_pkg;

    // column field and per-column storage
    localparam int COL_W       = 7;
    localparam int COLUMNS     = 80;
    localparam int COL_IDX_W   = $clog2(COLUMNS);
    localparam int SYM_W       = 6;
    localparam int RUN_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int THR_W       = 4;

    // symbol table
    localparam int             SYMBOL_COUNT = 35;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [THR_W-1:0]  THRESH_RESET = 4'd8;

    // linear congruential generator, modulus 2^31
    localparam int                SEED_W     = 31;
    localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd754864;

    // multiply: seed consumed four bits a cycle
    localparam int MUL_DIG_W  = 4;
    localparam int MUL_DIGITS = (SEED_W + MUL_DIG_W - 1) / MUL_DIG_W;

    // residues: seed streamed msb first, two bits a cycle
    localparam int MOD_DIG_W  = 2;
    localparam int MOD_DIGITS = (SEED_W + MOD_DIG_W - 1) / MOD_DIG_W;
    localparam int STREAM_W   = MOD_DIGITS * MOD_DIG_W;
    localparam int CNT_W      = $clog2(MOD_DIGITS);
    localparam int RES_W      = 6;
    localparam int RUN_MOD    = 9;
    localparam int DRAW_MOD   = 10;
    localparam int RUN_SHIFT  = 8;
    localparam int DRAW_SHIFT = 16;
    localparam int RUN_DIGIT  = RUN_SHIFT / MOD_DIG_W;
    localparam int DRAW_DIGIT = DRAW_SHIFT / MOD_DIG_W;

    // one stored column entry
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [RUN_W-1:0] run;
    } t_col_entry;

    // status from the random unit to the controller
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] rem_sym;
        logic [RES_W-1:0] rem_run;
        logic [RES_W-1:0] rem_draw;
    } t_rng_stat;

    typedef enum logic [1:0] {
        RNG_IDLE,
        RNG_MUL,
        RNG_MOD,
        RNG_DONE
    } t_rng_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RNG,
        S_DONE
    } t_ctl_state;

    // ascii code of a symbol index, unused slots read as space
    function automatic logic [CHAR_W-1:0] sym_code(input logic [SYM_W-1:0] idx);
        logic [CHAR_W-1:0] code;
        if (idx == '0) begin
            code = SPACE_CODE;
        end else if (idx <= 6'd10) begin
            code = 8'h30 + CHAR_W'(idx - 6'd1);
        end else if (idx <= 6'd33) begin
            code = 8'h41 + CHAR_W'(idx - 6'd11);
        end else if (idx == 6'd34) begin
            code = 8'h5A;
        end else begin
            code = SPACE_CODE;
        end
        return code;
    endfunction

    // one residue step: r = (4r + d) mod n, with r < n
    function automatic logic [RES_W-1:0] residue_step(
        input logic [RES_W-1:0]           r,
        input logic [MOD_DIG_W-1:0]       d,
        input logic [RES_W+MOD_DIG_W-1:0] n
    );
        logic [RES_W+MOD_DIG_W-1:0] x;
        logic [RES_W+MOD_DIG_W-1:0] n2;
        logic [RES_W+MOD_DIG_W-1:0] n3;
        x  = {r, d};
        n2 = n << 1;
        n3 = n2 + n;
        if (x >= n3) begin
            x = x - n3;
        end else if (x >= n2) begin
            x = x - n2;
        end else if (x >= n) begin
            x = x - n;
        end
        return RES_W'(x);
    endfunction

endpackage

// ===== rtl/crg_rng.sv =====
// ----------------------------------------------------------------------------
// crg_rng - digit-serial seed stepper and residue extractor
// Steps the shared 31-bit seed one multiplier digit a cycle, then streams the
// new seed msb first two bits a cycle to form seed mod 35, (seed>>8) mod 9 and
// (seed>>16) mod 10.
// ----------------------------------------------------------------------------
module crg_rng import crg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output t_rng_stat o_stat
);

    t_rng_state r_state, n_state;
    logic [SEED_W-1:0]   r_seed, n_seed;
    logic [SEED_W-1:0]   r_acc, n_acc;
    logic [SEED_W-1:0]   r_mul, n_mul;
    logic [SEED_W-1:0]   r_msh, n_msh;
    logic [STREAM_W-1:0] r_dsh, n_dsh;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [RES_W-1:0]    r_rsym, n_rsym;
    logic [RES_W-1:0]    r_rrun, n_rrun;
    logic [RES_W-1:0]    r_rdraw, n_rdraw;

    logic [SEED_W+MUL_DIG_W-1:0] mul_prod;
    logic [SEED_W-1:0]           mul_sum;
    logic [MOD_DIG_W-1:0]        mod_dig;

    // partial product of one seed digit, sum kept mod 2^31
    assign mul_prod = (SEED_W+MUL_DIG_W)'(r_mul) *
                      (SEED_W+MUL_DIG_W)'(r_msh[MUL_DIG_W-1:0]);
    assign mul_sum  = r_acc + mul_prod[SEED_W-1:0];
    assign mod_dig  = r_dsh[STREAM_W-1 -: MOD_DIG_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            RNG_IDLE: begin
                if (i_start) n_state = RNG_MUL;
            end
            RNG_MUL: begin
                if (r_cnt == '0) n_state = RNG_MOD;
            end
            RNG_MOD: begin
                if (r_cnt == '0) n_state = RNG_DONE;
            end
            RNG_DONE: begin
                n_state = i_start ? RNG_MUL : RNG_IDLE;
            end
            default: n_state = RNG_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stat.done     = (r_state == RNG_DONE);
        o_stat.rem_sym  = r_rsym;
        o_stat.rem_run  = r_rrun;
        o_stat.rem_draw = r_rdraw;
    end

    // datapath
    always_comb begin
        n_seed  = r_seed;
        n_acc   = r_acc;
        n_mul   = r_mul;
        n_msh   = r_msh;
        n_dsh   = r_dsh;
        n_cnt   = r_cnt;
        n_rsym  = r_rsym;
        n_rrun  = r_rrun;
        n_rdraw = r_rdraw;
        case (r_state)
            RNG_IDLE, RNG_DONE: begin
                if (i_start) begin
                    n_acc = LCG_ADD;
                    n_mul = LCG_MUL;
                    n_msh = r_seed;
                    n_cnt = CNT_W'(MUL_DIGITS - 1);
                end
            end
            RNG_MUL: begin
                n_acc = mul_sum;
                n_mul = r_mul << MUL_DIG_W;
                n_msh = r_msh >> MUL_DIG_W;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_seed  = mul_sum;
                    n_dsh   = STREAM_W'(mul_sum);
                    n_rsym  = '0;
                    n_rrun  = '0;
                    n_rdraw = '0;
                    n_cnt   = CNT_W'(MOD_DIGITS - 1);
                end
            end
            RNG_MOD: begin
                n_dsh  = r_dsh << MOD_DIG_W;
                n_cnt  = r_cnt - 1'b1;
                n_rsym = residue_step(r_rsym, mod_dig, (RES_W+MOD_DIG_W)'(SYMBOL_COUNT));
                if (int'(r_cnt) >= RUN_DIGIT) begin
                    n_rrun = residue_step(r_rrun, mod_dig, (RES_W+MOD_DIG_W)'(RUN_MOD));
                end
                if (int'(r_cnt) >= DRAW_DIGIT) begin
                    n_rdraw = residue_step(r_rdraw, mod_dig, (RES_W+MOD_DIG_W)'(DRAW_MOD));
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // control and seed registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RNG_IDLE;
            r_seed  <= SEED_RESET;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_mul   <= n_mul;
        r_msh   <= n_msh;
        r_dsh   <= n_dsh;
        r_cnt   <= n_cnt;
        r_rsym  <= n_rsym;
        r_rrun  <= n_rrun;
        r_rdraw <= n_rdraw;
    end

endmodule

// ===== rtl/column_rain_char_generator_unit.sv =====
// ----------------------------------------------------------------------------
// column_rain_char_generator_unit - falling-character column generator
// Produces the new top-row character of one text column per input word.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  (i_in_valid / o_in_ready, i_column): one column per word
//   output channel (o_out_valid / i_out_ready, o_column_out, o_char_code)
//   config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): blank threshold,
//   always ready; the user writes it only while the block is idle, unchecked
// One word is in flight at a time. A column with a blank start symbol and a
// run count above one needs no seed step; any other in-range column takes one
// or two. Every seed step runs through the digit-serial unit, 4 seed bits a
// cycle for the multiply and 2 bits a cycle for the residues.
// Columns at or above 80 return a space and touch no state.
// The result sits in an output register, so the next word is accepted while
// a stalled result waits; a finished item waits for that register to drain.
// Reset loads the seed with 754864, the threshold with 8, and clears the
// per-column valid bits so every column reads as blank with run count zero.
// ----------------------------------------------------------------------------
module column_rain_char_generator_unit import crg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [COL_W-1:0]  i_column,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [COL_W-1:0]  o_column_out,
    output logic [CHAR_W-1:0] o_char_code,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [THR_W-1:0]  i_cfg_data
);

    t_ctl_state r_state, n_state;

    logic [THR_W-1:0]  r_thr;
    logic [COL_W-1:0]  r_col;
    logic              r_in_range;
    t_col_entry        r_q;
    logic              r_q_vld;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic              r_pass, n_pass;

    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [CHAR_W-1:0] r_out_char;

    t_col_entry          r_mem [COLUMNS];
    logic [COLUMNS-1:0]  r_valid;

    logic [COL_IDX_W-1:0] rd_idx;
    logic [COL_IDX_W-1:0] wr_idx;
    logic                 in_range;
    logic                 in_acc;
    logic                 rng_start;
    logic                 out_load;
    logic                 mem_we;
    logic [SYM_W-1:0]     cur_sym;
    logic [RUN_W-1:0]     cur_run;
    logic                 need_rng;
    logic                 again;
    logic [SYM_W-1:0]     draw_sym;
    logic [CHAR_W-1:0]    draw_char;
    t_rng_stat            rng_stat;

    crg_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rng_start),
        .o_stat  (rng_stat)
    );

    // entry and decision helpers
    assign rd_idx    = COL_IDX_W'(i_column);
    assign wr_idx    = COL_IDX_W'(r_col);
    assign in_range  = int'(i_column) < COLUMNS;
    assign in_acc    = i_in_valid && o_in_ready;
    assign cur_sym   = r_q_vld ? r_q.sym : '0;
    assign cur_run   = r_q_vld ? r_q.run : '0;
    assign need_rng  = r_in_range && ((cur_sym != '0) || (cur_run <= RUN_W'(1)));
    assign again     = !r_pass && (r_run <= RUN_W'(1));
    assign draw_sym  = SYM_W'(rng_stat.rem_sym);
    assign draw_char = sym_code(draw_sym);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = need_rng ? S_RNG : S_DONE;
            end
            S_RNG: begin
                if (rng_stat.done && !again) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        rng_start  = ((r_state == S_LOAD) && need_rng) ||
                     ((r_state == S_RNG) && rng_stat.done && again);
        out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        mem_we     = out_load && r_in_range;
    end

    // column working values
    always_comb begin
        n_sym  = r_sym;
        n_run  = r_run;
        n_ch   = r_ch;
        n_pass = r_pass;
        case (r_state)
            S_LOAD: begin
                n_sym  = cur_sym;
                n_run  = cur_run;
                n_ch   = SPACE_CODE;
                n_pass = (cur_sym == '0);
                if (r_in_range && !need_rng) n_run = cur_run - 1'b1;
            end
            S_RNG: begin
                if (rng_stat.done) begin
                    if (!r_pass) begin
                        // symbol draw for a non-blank column
                        n_ch = draw_char;
                        if (again) begin
                            n_pass = 1'b1;
                        end else begin
                            n_run = r_run - 1'b1;
                        end
                    end else begin
                        // new run: length and blank or symbol
                        n_run = RUN_W'(rng_stat.rem_run);
                        if (rng_stat.rem_draw < RES_W'(r_thr)) begin
                            n_sym = '0;
                            n_ch  = SPACE_CODE;
                        end else begin
                            n_ch  = draw_char;
                            n_sym = (draw_char == SPACE_CODE) ? '0 : draw_sym;
                        end
                    end
                end
            end
            default: begin
                n_pass = r_pass;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THRESH_RESET;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_thr <= i_cfg_data;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (mem_we) r_valid[wr_idx] <= 1'b1;
        end
    end

    // column memory, registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && in_range) r_q <= r_mem[rd_idx];
        if (mem_we) r_mem[wr_idx] <= '{sym: r_sym, run: r_run};
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col      <= i_column;
            r_in_range <= in_range;
            r_q_vld    <= in_range && r_valid[rd_idx];
        end
        r_sym  <= n_sym;
        r_run  <= n_run;
        r_ch   <= n_ch;
        r_pass <= n_pass;
        if (out_load) begin
            r_out_col  <= r_col;
            r_out_char <= r_ch;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_column_out = r_out_col;
    assign o_char_code  = r_out_char;

    // checks
    a_oob_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (int'(o_column_out) >= COLUMNS)) |-> (o_char_code == SPACE_CODE))
        else $error("out-of-range column produced a non-space character");

    a_rng_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rng_start |-> ((r_state == S_LOAD) || ((r_state == S_RNG) && rng_stat.done)))
        else $error("seed step started while the random unit was busy");

    a_rng_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rng_stat.done |-> (r_state == S_RNG))
        else $error("random unit finished with no item waiting");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word appeared without a finished item");

endmodule

// ===== tb/crg_char_checker.sv =====
// ----------------------------------------------------------------------------
// crg_char_checker - result checker for the column rain character generator
// Watches the column, result and threshold channels, keeps its own copy of
// the seed and per-column state, and predicts the character of every
// accepted column word. Each result word is compared against the oldest
// prediction.
// ----------------------------------------------------------------------------
module crg_char_checker import crg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [COL_W-1:0]  i_column,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [COL_W-1:0]  i_column_out,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [THR_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] code;
    } t_char_word;

    // printable symbols, index 0 is the blank
    localparam string GLYPHS = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWZ";

    // shadow state of the generator
    logic [SEED_W-1:0] seed;
    logic [THR_W-1:0]  blank_thr;
    logic [SYM_W-1:0]  col_symbol [COLUMNS];
    logic [RUN_W-1:0]  col_run    [COLUMNS];

    t_char_word pending_chars[$];
    int         fail_total;

    // lcg step, mod 2^31 falls out of the 31-bit width
    function automatic logic [SEED_W-1:0] advance_seed();
        seed = LCG_MUL * seed + LCG_ADD;
        return seed;
    endfunction

    // ascii code of a symbol index, slots past the table are blank
    function automatic logic [CHAR_W-1:0] glyph_code(input logic [SYM_W-1:0] idx);
        logic [CHAR_W-1:0] code;
        code = SPACE_CODE;
        if (idx < SYMBOL_COUNT) begin
            code = GLYPHS[idx];
        end
        return code;
    endfunction

    // new top-row character of one column, updates the shadow state
    function automatic t_char_word next_char(input logic [COL_W-1:0] col);
        t_char_word        w;
        logic [SEED_W-1:0] s;
        logic [SYM_W-1:0]  idx;
        w.column = col;
        w.code   = SPACE_CODE;
        if (col < COLUMNS) begin
            if (col_symbol[col] != '0) begin
                s      = advance_seed();
                w.code = glyph_code(SYM_W'(s % SYMBOL_COUNT));
            end
            if (col_run[col] <= 1) begin
                s            = advance_seed();
                idx          = SYM_W'(s % SYMBOL_COUNT);
                col_run[col] = RUN_W'((s >> 8) % 9);
                if (((s >> 16) % 10) < blank_thr) begin
                    col_symbol[col] = '0;
                    w.code          = SPACE_CODE;
                end else begin
                    w.code          = glyph_code(idx);
                    col_symbol[col] = (w.code == SPACE_CODE) ? '0 : idx;
                end
            end else begin
                col_run[col] = col_run[col] - 1'b1;
            end
        end
        return w;
    endfunction

    // watch the channels at every rising edge
    always @(posedge i_clk) begin
        t_char_word w;
        if (!i_rst_n) begin
            seed      = SEED_RESET;
            blank_thr = THRESH_RESET;
            for (int c = 0; c < COLUMNS; c++) begin
                col_symbol[c] = '0;
                col_run[c]    = '0;
            end
            pending_chars.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                blank_thr = i_cfg_data;
            end
            // result word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pending_chars.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: unexpected result word col %0d char %02h",
                                 $realtime, i_column_out, i_char_code);
                    end
                end else begin
                    w = pending_chars.pop_front();
                    if (i_column_out !== w.column || i_char_code !== w.code) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: mismatch col exp %0d got %0d, char exp %02h got %02h",
                                     $realtime, w.column, i_column_out, w.code, i_char_code);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_chars.push_back(next_char(i_column));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_chars.size();
    end

endmodule

// ===== tb/tb_column_rain_char_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_column_rain_char_generator_unit - testbench of the rain char generator
// Drives column words through a directed opening and random phases under
// several blank thresholds, with random idle bursts on both channels, and
// leaves prediction and comparison to the checker instance.
// ----------------------------------------------------------------------------
module tb_column_rain_char_generator_unit import crg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_WORDS  = 55;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [COL_W-1:0]  column      = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [COL_W-1:0]  column_out;
    logic [CHAR_W-1:0] char_code;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [THR_W-1:0]  cfg_data    = '0;
    int                fail_count;
    int                pending;
    bit                quiet       = 1'b0;
    int                stall_left  = 0;

    column_rain_char_generator_unit i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_column     (column),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_column_out (column_out),
        .o_char_code  (char_code),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    crg_char_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_column     (column),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_column_out (column_out),
        .i_char_code  (char_code),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side back-pressure in short bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 4) - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // one column word, with an optional idle burst ahead of it
    task automatic send_column(input logic [COL_W-1:0] col);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        column   <= col;
        do @(posedge clk); while (!in_ready);
    endtask

    // random column, often one of the hot columns 0 to 7 so runs evolve
    function automatic logic [COL_W-1:0] pick_column();
        logic [COL_W-1:0] col;
        if ($urandom_range(0, 99) < 12) begin
            col = COL_W'($urandom_range(COLUMNS, 127));
        end else if ($urandom_range(0, 1) == 0) begin
            col = COL_W'($urandom_range(0, 7));
        end else begin
            col = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        return col;
    endfunction

    // stop sending and wait until every prediction has been matched
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // threshold write while the block is idle
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [COL_W-1:0] opening [20];
        logic [THR_W-1:0] thresholds [7];
        opening    = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd79, 7'd80, 7'd127, 7'd85, 7'd42, 7'd1,
                       7'd0, 7'd0, 7'd79, 7'd79, 7'd64, 7'd63, 7'd0, 7'd1, 7'd127, 7'd0};
        thresholds = '{4'd0, 4'd15, 4'd10, 4'd11, 4'd5, 4'd9, 4'd2};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at the reset threshold
        foreach (opening[k]) begin
            send_column(opening[k]);
        end
        drain();

        // random phases, last one without idle bursts
        foreach (thresholds[p]) begin
            write_threshold(thresholds[p]);
            if (p == 6) begin
                quiet = 1'b1;
            end
            repeat (PHASE_WORDS) begin
                send_column(pick_column());
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/crg_pkg.sv
rtl/crg_rng.sv
rtl/column_rain_char_generator_unit.sv
tb/crg_char_checker.sv
tb/tb_column_rain_char_generator_unit.sv
